/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the matcher checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Payload held while a transaction is stalled.
`define ASSERT_HOLD(lbl, clk, rst, vld, rdy, pay, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    ($past(vld) && !$past(rdy) && !$past(rst)) |-> (vld && $stable(pay))) else $error(msg);

`endif

/* rtl/core/mpsm_pkg.sv */
// ----------------------------------------------------------------------------
// mpsm_pkg
// Types and constants of the multi-pattern string matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

  localparam int NODES_DEF    = 4096;
  localparam int ALPHABET_DEF = 26;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_BUILD  = 2'd2,
    ACT_SCAN   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_PHASE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] symbol;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       match_here;
    logic       found;
    logic       text_end;
  } result_t;

  typedef struct packed {
    action_t    action;
    logic [4:0] symbol;
    logic       last;
    logic       sym_ok;
  } cmd_t;

endpackage

/* rtl/core/mpsm_ram.sv */
// ----------------------------------------------------------------------------
// mpsm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mpsm_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/mpsm_front.sv */
// ----------------------------------------------------------------------------
// mpsm_front
// Accepts items, classifies the letter, and queues commands for the engine.
// ----------------------------------------------------------------------------
module mpsm_front #(
  parameter int ALPHABET = mpsm_pkg::ALPHABET_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  mpsm_pkg::item_t item,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output mpsm_pkg::cmd_t  cmd
);
  import mpsm_pkg::*;

  cmd_t       fifo [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       incoming;

  always_comb begin
    incoming.action = action_t'(item.action);
    incoming.symbol = item.symbol;
    incoming.last   = item.last;
    incoming.sym_ok = 9'(item.symbol) < 9'(ALPHABET);
  end

  assign item_ready = !rst && count != 2'd2;
  assign cmd_valid  = count != 2'd0;
  assign cmd        = fifo[rptr];
  assign push       = item_valid && item_ready;
  assign pop        = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= incoming;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* rtl/core/mpsm_back.sv */
// ----------------------------------------------------------------------------
// mpsm_back
// Trie engine: clear, insert, failure-link build, scan, and the result register.
// ----------------------------------------------------------------------------
module mpsm_back #(
  parameter int NODES    = mpsm_pkg::NODES_DEF,
  parameter int ALPHABET = mpsm_pkg::ALPHABET_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  mpsm_pkg::cmd_t    cmd,
  output logic              result_valid,
  input  logic              result_ready,
  output mpsm_pkg::result_t result
);
  import mpsm_pkg::*;

  localparam int NW       = $clog2(NODES);
  localparam int SW       = $clog2(ALPHABET);
  localparam int CW       = NW + 1;
  localparam int NT_DEPTH = NODES * (2 ** SW);

  typedef enum logic [18:0] {
    S_IDLE      = 19'h00001,
    S_ZERO      = 19'h00002,
    S_INS_RD    = 19'h00004,
    S_INS_CHK   = 19'h00008,
    S_INS_LINK  = 19'h00010,
    S_BLD_ROOT  = 19'h00020,
    S_BLD_ROOT2 = 19'h00040,
    S_BLD_POP   = 19'h00080,
    S_BLD_Q     = 19'h00100,
    S_BLD_F     = 19'h00200,
    S_BLD_A1    = 19'h00400,
    S_BLD_A2    = 19'h00800,
    S_BLD_RC    = 19'h01000,
    S_BLD_RV    = 19'h02000,
    S_BLD_WR    = 19'h04000,
    S_SCN_RD    = 19'h08000,
    S_SCN_ACC   = 19'h10000,
    S_SCN_RES   = 19'h20000,
    S_EMIT      = 19'h40000
  } state_t;

  localparam logic [SW-1:0] SYM_LAST = SW'(ALPHABET - 1);

  state_t        state;
  cmd_t          cur_cmd;
  logic [CW-1:0] node_count;
  logic [NW-1:0] insert_cursor;
  logic [NW-1:0] scan_cursor;
  logic          found_flag;
  logic          built_flag;
  logic          pattern_failed;
  logic          boot;
  logic          zero_ins;
  logic [NW-1:0] zrow;
  logic [NW-1:0] child;
  logic [SW-1:0] sym_idx;
  logic [SW-1:0] sym_cnt;
  logic [NW-1:0] head;
  logic [NW-1:0] tail;
  logic [NW-1:0] u_node;
  logic [NW-1:0] f_node;
  logic [NW-1:0] c_node;
  logic          acc_f;
  logic          emit_go;
  result_t       res;

  logic [NW+SW-1:0] nt_raddr, nt_waddr;
  logic [NW-1:0]    nt_wdata, nt_rdata;
  logic             nt_we;
  logic [NW-1:0]    fl_raddr, fl_waddr, fl_wdata, fl_rdata;
  logic             fl_we;
  logic [NW-1:0]    acc_raddr, acc_waddr;
  logic             acc_wdata, acc_rdata, acc_we;
  logic [NW-1:0]    bq_raddr, bq_waddr, bq_wdata, bq_rdata;
  logic             bq_we;
  logic [NW-1:0]    scan_nx;

  assign sym_idx   = SW'(cur_cmd.symbol);
  assign cmd_ready = state == S_IDLE;
  assign scan_nx   = cur_cmd.sym_ok ? nt_rdata : '0;
  assign emit_go   = (state == S_EMIT) && (!result_valid || result_ready);

  always_comb begin
    nt_raddr  = '0;
    nt_we     = 1'b0;
    nt_waddr  = '0;
    nt_wdata  = '0;
    fl_raddr  = bq_rdata;
    fl_we     = 1'b0;
    fl_waddr  = '0;
    fl_wdata  = '0;
    acc_raddr = '0;
    acc_we    = 1'b0;
    acc_waddr = '0;
    acc_wdata = 1'b0;
    bq_raddr  = head;
    bq_we     = 1'b0;
    bq_waddr  = tail;
    bq_wdata  = '0;
    unique case (state)
      S_ZERO: begin
        nt_we     = 1'b1;
        nt_waddr  = {zrow, sym_cnt};
        acc_we    = 1'b1;
        acc_waddr = zrow;
      end
      S_INS_RD:  nt_raddr = {insert_cursor, sym_idx};
      S_INS_CHK: begin
        if (nt_rdata != '0 && cur_cmd.last) begin
          acc_we    = 1'b1;
          acc_waddr = nt_rdata;
          acc_wdata = 1'b1;
        end
      end
      S_INS_LINK: begin
        nt_we     = 1'b1;
        nt_waddr  = {insert_cursor, sym_idx};
        nt_wdata  = child;
        acc_we    = 1'b1;
        acc_waddr = child;
        acc_wdata = cur_cmd.last;
      end
      S_BLD_ROOT: nt_raddr = {{NW{1'b0}}, sym_cnt};
      S_BLD_ROOT2: begin
        if (nt_rdata != '0) begin
          fl_we    = 1'b1;
          fl_waddr = nt_rdata;
          bq_we    = 1'b1;
          bq_wdata = nt_rdata;
        end
      end
      S_BLD_F:  acc_raddr = fl_rdata;
      S_BLD_A1: acc_raddr = u_node;
      S_BLD_A2: begin
        acc_we    = 1'b1;
        acc_waddr = u_node;
        acc_wdata = acc_rdata | acc_f;
      end
      S_BLD_RC: nt_raddr = {u_node, sym_cnt};
      S_BLD_RV: nt_raddr = {f_node, sym_cnt};
      S_BLD_WR: begin
        if (c_node != '0) begin
          fl_we    = 1'b1;
          fl_waddr = c_node;
          fl_wdata = nt_rdata;
          bq_we    = 1'b1;
          bq_wdata = c_node;
        end else begin
          nt_we    = 1'b1;
          nt_waddr = {u_node, sym_cnt};
          nt_wdata = nt_rdata;
        end
      end
      S_SCN_RD:  nt_raddr = {scan_cursor, sym_idx};
      S_SCN_ACC: acc_raddr = scan_nx;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_ZERO;
      boot           <= 1'b1;
      zero_ins       <= 1'b0;
      zrow           <= '0;
      sym_cnt        <= '0;
      node_count     <= CW'(1);
      insert_cursor  <= '0;
      scan_cursor    <= '0;
      found_flag     <= 1'b0;
      built_flag     <= 1'b0;
      pattern_failed <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_cmd        <= cmd;
            res.match_here <= 1'b0;
            res.found      <= 1'b0;
            res.text_end   <= 1'b0;
            unique case (cmd.action)
              ACT_CLEAR: begin
                res.status     <= ST_OK;
                node_count     <= CW'(1);
                insert_cursor  <= '0;
                scan_cursor    <= '0;
                found_flag     <= 1'b0;
                built_flag     <= 1'b0;
                pattern_failed <= 1'b0;
                zrow           <= '0;
                sym_cnt        <= '0;
                zero_ins       <= 1'b0;
                state          <= S_ZERO;
              end
              ACT_INSERT: begin
                if (built_flag) begin
                  res.status <= ST_PHASE;
                  state      <= S_EMIT;
                end else if (pattern_failed) begin
                  res.status <= ST_FULL;
                  state      <= S_EMIT;
                  if (cmd.last) begin
                    insert_cursor  <= '0;
                    pattern_failed <= 1'b0;
                  end
                end else if (!cmd.sym_ok) begin
                  res.status <= ST_PHASE;
                  state      <= S_EMIT;
                  if (cmd.last) begin
                    insert_cursor <= '0;
                  end else begin
                    pattern_failed <= 1'b1;
                  end
                end else begin
                  res.status <= ST_OK;
                  state      <= S_INS_RD;
                end
              end
              ACT_BUILD: begin
                if (built_flag || insert_cursor != '0 || pattern_failed) begin
                  res.status <= ST_PHASE;
                  state      <= S_EMIT;
                end else begin
                  res.status <= ST_OK;
                  sym_cnt    <= '0;
                  head       <= '0;
                  tail       <= '0;
                  state      <= S_BLD_ROOT;
                end
              end
              ACT_SCAN: begin
                if (!built_flag) begin
                  res.status <= ST_PHASE;
                  state      <= S_EMIT;
                end else begin
                  res.status <= ST_OK;
                  state      <= S_SCN_RD;
                end
              end
              default: begin
                res.status <= ST_OK;
                state      <= S_EMIT;
              end
            endcase
          end
        end
        S_ZERO: begin
          if (sym_cnt == SYM_LAST) begin
            boot    <= 1'b0;
            sym_cnt <= '0;
            if (zero_ins) begin
              state <= S_INS_LINK;
            end else if (boot) begin
              state <= S_IDLE;
            end else begin
              state <= S_EMIT;
            end
          end else begin
            sym_cnt <= sym_cnt + SW'(1);
          end
        end
        S_INS_RD: state <= S_INS_CHK;
        S_INS_CHK: begin
          if (nt_rdata != '0) begin
            insert_cursor <= cur_cmd.last ? '0 : nt_rdata;
            state         <= S_EMIT;
          end else if (node_count == CW'(NODES)) begin
            res.status <= ST_FULL;
            if (cur_cmd.last) begin
              insert_cursor <= '0;
            end else begin
              pattern_failed <= 1'b1;
            end
            state <= S_EMIT;
          end else begin
            child      <= node_count[NW-1:0];
            zrow       <= node_count[NW-1:0];
            node_count <= node_count + CW'(1);
            sym_cnt    <= '0;
            zero_ins   <= 1'b1;
            state      <= S_ZERO;
          end
        end
        S_INS_LINK: begin
          insert_cursor <= cur_cmd.last ? '0 : child;
          state         <= S_EMIT;
        end
        S_BLD_ROOT: state <= S_BLD_ROOT2;
        S_BLD_ROOT2: begin
          if (nt_rdata != '0) begin
            tail <= tail + NW'(1);
          end
          if (sym_cnt == SYM_LAST) begin
            sym_cnt <= '0;
            state   <= S_BLD_POP;
          end else begin
            sym_cnt <= sym_cnt + SW'(1);
            state   <= S_BLD_ROOT;
          end
        end
        S_BLD_POP: begin
          if (head == tail) begin
            built_flag <= 1'b1;
            state      <= S_EMIT;
          end else begin
            state <= S_BLD_Q;
          end
        end
        S_BLD_Q: begin
          u_node <= bq_rdata;
          head   <= head + NW'(1);
          state  <= S_BLD_F;
        end
        S_BLD_F: begin
          f_node <= fl_rdata;
          state  <= S_BLD_A1;
        end
        S_BLD_A1: begin
          acc_f <= acc_rdata;
          state <= S_BLD_A2;
        end
        S_BLD_A2: begin
          sym_cnt <= '0;
          state   <= S_BLD_RC;
        end
        S_BLD_RC: state <= S_BLD_RV;
        S_BLD_RV: begin
          c_node <= nt_rdata;
          state  <= S_BLD_WR;
        end
        S_BLD_WR: begin
          if (c_node != '0) begin
            tail <= tail + NW'(1);
          end
          if (sym_cnt == SYM_LAST) begin
            sym_cnt <= '0;
            state   <= S_BLD_POP;
          end else begin
            sym_cnt <= sym_cnt + SW'(1);
            state   <= S_BLD_RC;
          end
        end
        S_SCN_RD: state <= S_SCN_ACC;
        S_SCN_ACC: begin
          scan_cursor <= scan_nx;
          state       <= S_SCN_RES;
        end
        S_SCN_RES: begin
          res.match_here <= acc_rdata;
          res.found      <= found_flag | acc_rdata;
          res.text_end   <= cur_cmd.last;
          if (cur_cmd.last) begin
            scan_cursor <= '0;
            found_flag  <= 1'b0;
          end else begin
            found_flag <= found_flag | acc_rdata;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_go) begin
      result_valid <= 1'b1;
      result       <= res;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  mpsm_ram #(.W(NW), .D(NT_DEPTH)) u_next_table (
    .clk(clk), .we(nt_we), .waddr(nt_waddr), .wdata(nt_wdata),
    .raddr(nt_raddr), .rdata(nt_rdata)
  );

  mpsm_ram #(.W(NW), .D(NODES)) u_fail_link (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(fl_raddr), .rdata(fl_rdata)
  );

  mpsm_ram #(.W(1), .D(NODES)) u_accept_mark (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  mpsm_ram #(.W(NW), .D(NODES)) u_bfs_queue (
    .clk(clk), .we(bq_we), .waddr(bq_waddr), .wdata(bq_wdata),
    .raddr(bq_raddr), .rdata(bq_rdata)
  );

endmodule

/* rtl/core/multi_pattern_string_matcher.sv */
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// Dense-alphabet Aho-Corasick matcher: trie insert, link build, text scan.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (valid/ready) carries action, symbol and last; result
//   channel (valid/ready) returns one status/match_here/found/text_end per
//   item, in order. A two-entry queue sits between the front and the trie
//   engine, so items are taken while the engine or the receiver is busy.
// Engine steps per item, set by the registered reads of the trie tables;
// the engine takes one item at a time:
//   scan   table read, then accept read; rejected items go straight to result
//   insert table read, plus a cleared row and a link when a node is allocated
//   clear  root row cleared one entry a cycle
//   build  root row queued, then per trie node its fail link, accept mark and row
// Reset: item_ready is low during rst; then the engine clears the root row
//   while items queue. Acts like a clear with no result.
// Receiver stall: the result register holds its transaction; the engine
//   waits with the next result and the queue fills, then item_ready drops.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher #(
  parameter int NODES    = mpsm_pkg::NODES_DEF,
  parameter int ALPHABET = mpsm_pkg::ALPHABET_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  mpsm_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output mpsm_pkg::result_t result
);
  import mpsm_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  mpsm_front #(.ALPHABET(ALPHABET)) u_front (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  mpsm_back #(.NODES(NODES), .ALPHABET(ALPHABET)) u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

endmodule

/* rtl/core/mpsm_checker.sv */
// ----------------------------------------------------------------------------
// mpsm_checker
// Port-level checks on the matcher result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpsm_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input mpsm_pkg::result_t result
);
  import mpsm_pkg::*;

  `ASSERT_HOLD(a_result_hold, clk, rst, result_valid, result_ready, result,
               "result changed under stall")
  `ASSERT_CLK(a_status_code, clk, rst, result_valid |-> (result.status != 2'd3), "bad status")
  `ASSERT_CLK(a_reject_quiet, clk, rst,
              (result_valid && result.status != ST_OK) |->
                (!result.match_here && !result.found && !result.text_end),
              "flags on rejected transaction")
  `ASSERT_CLK(a_match_found, clk, rst, (result_valid && result.match_here) |-> result.found,
              "match without found")

endmodule

bind multi_pattern_string_matcher mpsm_checker u_mpsm_checker (
  .clk(clk), .rst(rst), .result_valid(result_valid),
  .result_ready(result_ready), .result(result)
);
